/* src/pvbu_pkg.sv */
`default_nettype none
package pvbu_pkg;

  localparam int unsigned MAX_FFT_DEF      = 4096;
  localparam int unsigned PHASE_BITS_DEF   = 16;
  localparam int unsigned CORDIC_STEPS_DEF = 16;

  localparam int unsigned LG_MIN = 5;

  // 1/K^2 in Q30
  localparam logic [28:0] INV_K2_Q30 = 29'd395948868;

  typedef enum logic [2:0] {
    CFG_OVERLAP    = 3'd0,
    CFG_RETENTION  = 3'd1,
    CFG_SCALE      = 3'd2,
    CFG_PHASE_GAIN = 3'd3,
    CFG_FFT_LOG2   = 3'd4
  } cfg_index_t;

  // atan(2^-k) in turns, rounded to p fraction bits
  function automatic logic [31:0] angle_step(input int unsigned k, input int unsigned p);
    logic [63:0] t;
    case (k)
      0:  t = 64'd536870912;
      1:  t = 64'd316933406;
      2:  t = 64'd167458907;
      3:  t = 64'd85004756;
      4:  t = 64'd42667331;
      5:  t = 64'd21354465;
      6:  t = 64'd10679838;
      7:  t = 64'd5340245;
      8:  t = 64'd2670163;
      9:  t = 64'd1335087;
      10: t = 64'd667544;
      11: t = 64'd333772;
      12: t = 64'd166886;
      13: t = 64'd83443;
      14: t = 64'd41722;
      15: t = 64'd20861;
      16: t = 64'd10430;
      17: t = 64'd5215;
      18: t = 64'd2608;
      19: t = 64'd1304;
      20: t = 64'd652;
      21: t = 64'd326;
      22: t = 64'd163;
      23: t = 64'd81;
      default: t = 64'd0;
    endcase
    t = (t + (64'd1 << (31 - p))) >> (32 - p);
    return t[31:0];
  endfunction

  function automatic logic [23:0] sat24(input logic signed [29:0] v);
    logic [23:0] r;
    if (v > 30'sd8388607) r = 24'h7FFFFF;
    else if (v < -30'sd8388608) r = 24'h800000;
    else r = v[23:0];
    return r;
  endfunction

endpackage
`default_nettype wire

/* src/pvbu_cell.sv */
`default_nettype none
module pvbu_cell #(
  parameter int unsigned XW = 35,
  parameter int unsigned ZW = 18,
  parameter int unsigned P  = 16,
  parameter int unsigned K  = 0
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire logic                 in_rot,
  input  wire logic signed [XW-1:0] x_in,
  input  wire logic signed [XW-1:0] y_in,
  input  wire logic signed [ZW-1:0] z_in,
  output logic                      out_valid,
  output logic                      out_rot,
  output logic signed [XW-1:0]      x_out,
  output logic signed [XW-1:0]      y_out,
  output logic signed [ZW-1:0]      z_out
);

  localparam logic signed [ZW-1:0] A = ZW'(pvbu_pkg::angle_step(K, P));

  logic signed [XW-1:0] xs, ys;
  assign xs = x_in >>> K;
  assign ys = y_in >>> K;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_rot <= in_rot;
    if (in_rot) begin
      if (z_in >= 0) begin
        x_out <= x_in - ys;
        y_out <= y_in + xs;
        z_out <= z_in - A;
      end else begin
        x_out <= x_in + ys;
        y_out <= y_in - xs;
        z_out <= z_in + A;
      end
    end else begin
      if (y_in >= 0) begin
        x_out <= x_in + ys;
        y_out <= y_in - xs;
        z_out <= z_in + A;
      end else begin
        x_out <= x_in - ys;
        y_out <= y_in + xs;
        z_out <= z_in - A;
      end
    end
  end

endmodule
`default_nettype wire

/* src/pvbu_div.sv */
`default_nettype none
module pvbu_div #(
  parameter int unsigned NW = 29
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [4:0]    den,
  output logic               done,
  output logic [NW-1:0]      quo
);

  localparam int unsigned CW = $clog2(NW + 1);

  logic [4:0]    rem;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [5:0]    r;

  assign r = {rem, quo[NW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CW'(NW);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // restoring division, numerator shifts out as quotient shifts in
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= num;
    end else if (busy) begin
      if (r >= {1'b0, den}) begin
        rem <= 5'(r - {1'b0, den});
        quo <= {quo[NW-2:0], 1'b1};
      end else begin
        rem <= r[4:0];
        quo <= {quo[NW-2:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

/* src/phase_vocoder_bin_update.sv */
// Phase vocoder bin update: one forward-FFT bin per item in, the bin rotated
// to its propagated synthesis phase out.
// Input channel in_valid/in_stall carries kind, bin_index, re_in, im_in and
// frame_end. Output channel out_valid/out_stall carries bin_out, re_out,
// im_out and last_out. Config writes go over cfg_valid/cfg_ready with
// cfg_index and cfg_data; cfg_ready is always high.
// One item is in work at a time. A bin between DC and Nyquist starts the
// vectoring pass at its accept; the bit-serial divider for the ideal advance,
// NW = 13 + PHASE_BITS bits wide (29 at default widths), runs alongside the
// vectoring pass and is the longer of the two at default widths, then the
// rotation pass goes through the same row of cells.
// DC, Nyquist and higher bins go straight from the accept to the output state.
// The next item is taken the cycle after a result is loaded.
// A clear item yields no result and, like reset, starts a clearing pass over
// all MAX_FFT/2+1 entries of the per-bin memory, while in_stall stays high.
// The result sits in an output register; while out_stall holds it there the
// block finishes the next item and waits before loading it.
`default_nettype none
module phase_vocoder_bin_update #(
  parameter int unsigned MAX_FFT      = pvbu_pkg::MAX_FFT_DEF,
  parameter int unsigned PHASE_BITS   = pvbu_pkg::PHASE_BITS_DEF,
  parameter int unsigned CORDIC_STEPS = pvbu_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        kind,
  input  wire logic [11:0] bin_index,
  input  wire logic [23:0] re_in,
  input  wire logic [23:0] im_in,
  input  wire logic        frame_end,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [11:0]      bin_out,
  output logic [23:0]      re_out,
  output logic [23:0]      im_out,
  output logic             last_out,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int unsigned P      = PHASE_BITS;
  localparam int unsigned NB     = MAX_FFT / 2 + 1;
  localparam int unsigned AW     = $clog2(NB);
  localparam int unsigned MW     = 2 * P + 32;
  localparam int unsigned XW     = 35;
  localparam int unsigned ZW     = P + 2;
  localparam int unsigned NW     = 12 + P + 1;
  localparam int unsigned MAXLOG = $clog2(MAX_FFT);

  typedef enum logic [9:0] {
    S_CLR  = 10'b0000000001,
    S_IDLE = 10'b0000000010,
    S_VEC  = 10'b0000000100,
    S_M1   = 10'b0000001000,
    S_M2   = 10'b0000010000,
    S_M3   = 10'b0000100000,
    S_ROT  = 10'b0001000000,
    S_SC1  = 10'b0010000000,
    S_SC2  = 10'b0100000000,
    S_OUT  = 10'b1000000000
  } state_t;

  state_t state;

  // configuration
  logic [4:0]  overlap;
  logic [15:0] retention, scale, phase_gain;
  logic [3:0]  fft_size_log2;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      overlap       <= 5'd4;
      retention     <= 16'd16384;
      scale         <= 16'd4096;
      phase_gain    <= 16'd16384;
      fft_size_log2 <= 4'd10;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pvbu_pkg::CFG_OVERLAP:    overlap       <= cfg_data[4:0];
        pvbu_pkg::CFG_RETENTION:  retention     <= cfg_data;
        pvbu_pkg::CFG_SCALE:      scale         <= cfg_data;
        pvbu_pkg::CFG_PHASE_GAIN: phase_gain    <= cfg_data;
        pvbu_pkg::CFG_FFT_LOG2:   fft_size_log2 <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // nyquist bound
  logic [3:0]  lg;
  logic [12:0] half_n;
  always_comb begin
    if (fft_size_log2 < 4'(pvbu_pkg::LG_MIN)) lg = 4'(pvbu_pkg::LG_MIN);
    else if (fft_size_log2 > 4'(MAXLOG)) lg = 4'(MAXLOG);
    else lg = fft_size_log2;
    half_n = 13'd1 << (lg - 4'd1);
  end

  logic accept, bypass;
  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign bypass   = (bin_index == 12'd0) || ({1'b0, bin_index} >= half_n);

  // per-bin memory: {prev_phase, prev_true_freq, synth_phase}
  logic [MW-1:0] mem [NB];
  logic [MW-1:0] rdata;
  logic          we;
  logic [AW-1:0] waddr;
  logic [MW-1:0] wdata;
  logic [AW-1:0] clr_cnt;
  logic [AW-1:0] addr;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (accept) rdata <= mem[bin_index[AW-1:0]];
  end

  // item registers
  logic        zin;
  logic [4:0]  ov;
  logic [11:0] bin_r;
  logic        last_r;
  logic [23:0] re_r, im_r;
  assign ov = (overlap == 5'd0) ? 5'd1 : overlap;

  // divider
  logic          div_start, div_done;
  logic [NW-1:0] div_num, ideal;
  assign div_start = accept && !kind && !bypass;
  assign div_num   = (NW'(bin_index) << P) + NW'(ov[4:1]);

  pvbu_div #(.NW(NW)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(ov),
    .done(div_done), .quo(ideal)
  );

  // cell row
  logic                 cv [CORDIC_STEPS+1];
  logic                 cr [CORDIC_STEPS+1];
  logic signed [XW-1:0] cx [CORDIC_STEPS+1];
  logic signed [XW-1:0] cy [CORDIC_STEPS+1];
  logic signed [ZW-1:0] cz [CORDIC_STEPS+1];

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cell
    pvbu_cell #(.XW(XW), .ZW(ZW), .P(P), .K(k)) u_cell (
      .clk(clk), .rst(rst),
      .in_valid(cv[k]), .in_rot(cr[k]), .x_in(cx[k]), .y_in(cy[k]), .z_in(cz[k]),
      .out_valid(cv[k+1]), .out_rot(cr[k+1]),
      .x_out(cx[k+1]), .y_out(cy[k+1]), .z_out(cz[k+1])
    );
  end

  logic signed [XW-1:0] xm, xr, yr;
  logic signed [ZW-1:0] zp;
  logic                 vdone;

  // multiply stages
  logic [P-1:0]            phase_r;
  logic [31:0]             tf_r;
  logic signed [P+16:0]    p1;
  logic [31:0]             p2;
  logic signed [48:0]      p3lo, p3hi;
  logic [P-1:0]            pp, sp;
  logic [31:0]             ptf;
  logic [P-1:0]            dev;
  logic [63:0]             tf64, sum, sum_rnd;
  logic [P-1:0]            newph;
  logic signed [ZW-1:0]    zr0;
  logic signed [XW-1:0]    xr0;
  logic signed [ZW-1:0]    quarter, half;

  assign pp  = rdata[MW-1 -: P];
  assign ptf = rdata[P+31:P];
  assign sp  = rdata[P-1:0];
  assign dev = zp[P-1:0] - pp - ideal[P-1:0];
  assign tf64 = 64'(ideal) + {{(64-P){dev[P-1]}}, dev};
  assign sum  = ({{(47-P){p1[P+16]}}, p1} << 12) + {{15{p3lo[48]}}, p3lo}
              + ({{15{p3hi[48]}}, p3hi} << 16);
  assign sum_rnd = sum + (64'd1 << 25);
  assign newph   = sum_rnd[P+25:26];
  assign quarter = ZW'(1) << (P - 2);
  assign half    = ZW'(1) << (P - 1);

  always_comb begin
    zr0 = ZW'($signed(newph));
    xr0 = xm;
    if (zr0 > quarter) begin
      xr0 = -xm;
      zr0 = zr0 - half;
    end else if (zr0 < -quarter) begin
      xr0 = -xm;
      zr0 = zr0 + half;
    end
  end

  // row input: vectoring at accept, rotation after the phase update
  logic signed [XW-1:0] xv, yv;
  always_comb begin
    xv = XW'($signed(re_in)) <<< 6;
    yv = XW'($signed(im_in)) <<< 6;
    cv[0] = 1'b0;
    cr[0] = 1'b0;
    cx[0] = xv;
    cy[0] = yv;
    cz[0] = '0;
    if (div_start) begin
      cv[0] = 1'b1;
      if (xv < 0) begin
        cx[0] = -xv;
        cy[0] = -yv;
        cz[0] = half;
      end
    end else if (state == S_M3) begin
      cv[0] = 1'b1;
      cr[0] = 1'b1;
      cx[0] = xr0;
      cy[0] = '0;
      cz[0] = zr0;
    end
  end

  // memory write port
  always_comb begin
    we    = 1'b0;
    waddr = clr_cnt;
    wdata = '0;
    if (state == S_CLR) begin
      we = 1'b1;
    end else if (state == S_M3) begin
      we    = 1'b1;
      waddr = addr;
      wdata = {phase_r, tf_r, newph};
    end
  end

  // output scaling
  logic signed [46:0] phx, phy;
  logic        [46:0] plx, ply;
  logic signed [65:0] totx, toty;
  assign totx = (66'(phx) <<< 18) + 66'($signed({1'b0, plx})) + (66'sd1 <<< 35);
  assign toty = (66'(phy) <<< 18) + 66'($signed({1'b0, ply})) + (66'sd1 <<< 35);

  logic out_load;
  assign out_load = (state == S_OUT) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_cnt   <= '0;
      vdone     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      case (state)
        S_CLR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == AW'(NB - 1)) begin
            clr_cnt <= '0;
            state   <= S_IDLE;
          end
        end
        S_IDLE: begin
          vdone <= 1'b0;
          if (accept) begin
            if (kind) state <= S_CLR;
            else if (bypass) state <= S_OUT;
            else state <= S_VEC;
          end
        end
        S_VEC: begin
          if (cv[CORDIC_STEPS]) vdone <= 1'b1;
          if (vdone && div_done) state <= S_M1;
        end
        S_M1:  state <= S_M2;
        S_M2:  state <= S_M3;
        S_M3:  state <= S_ROT;
        S_ROT: if (cv[CORDIC_STEPS]) state <= S_SC1;
        S_SC1: state <= S_SC2;
        S_SC2: state <= S_OUT;
        S_OUT: if (out_load) state <= S_IDLE;
        default: state <= S_CLR;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      addr   <= bin_index[AW-1:0];
      zin    <= (re_in == 24'd0) && (im_in == 24'd0);
      bin_r  <= bin_index;
      last_r <= frame_end;
      re_r   <= re_in;
      im_r   <= im_in;
    end
    if (state == S_VEC && cv[CORDIC_STEPS]) begin
      xm <= zin ? '0 : cx[CORDIC_STEPS];
      zp <= zin ? '0 : cz[CORDIC_STEPS];
    end
    if (state == S_M1) begin
      phase_r <= zp[P-1:0];
      tf_r    <= tf64[31:0];
      p1      <= $signed(sp) * $signed({1'b0, retention});
      p2      <= scale * phase_gain;
    end
    if (state == S_M2) begin
      p3lo <= $signed(ptf) * $signed({1'b0, p2[15:0]});
      p3hi <= $signed(ptf) * $signed({1'b0, p2[31:16]});
    end
    if (state == S_ROT && cv[CORDIC_STEPS]) begin
      xr <= cx[CORDIC_STEPS];
      yr <= cy[CORDIC_STEPS];
    end
    if (state == S_SC1) begin
      phx <= $signed(xr[XW-1:18]) * $signed({1'b0, pvbu_pkg::INV_K2_Q30});
      phy <= $signed(yr[XW-1:18]) * $signed({1'b0, pvbu_pkg::INV_K2_Q30});
      plx <= xr[17:0] * pvbu_pkg::INV_K2_Q30;
      ply <= yr[17:0] * pvbu_pkg::INV_K2_Q30;
    end
    if (state == S_SC2) begin
      re_r <= pvbu_pkg::sat24(totx[65:36]);
      im_r <= pvbu_pkg::sat24(toty[65:36]);
    end
    // output register only changes when the previous item has left
    if (out_load) begin
      bin_out  <= bin_r;
      last_out <= last_r;
      re_out   <= re_r;
      im_out   <= im_r;
    end
  end

endmodule
`default_nettype wire

/* tb/bin_update_checker.sv */
module bin_update_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic        kind,
  input  wire logic [11:0] bin_index,
  input  wire logic [23:0] re_in,
  input  wire logic [23:0] im_in,
  input  wire logic        frame_end,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [11:0] bin_out,
  input  wire logic [23:0] re_out,
  input  wire logic [23:0] im_out,
  input  wire logic        last_out,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  output int               pending,
  output int               failures
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic KIND_CLEAR = 1'b1;
  localparam int NUM_BINS = 2049;
  localparam int PB = 16;
  localparam longint PMASK = 64'hFFFF;

  typedef struct {
    logic [11:0] bin;
    logic [23:0] re;
    logic [23:0] im;
    logic        last;
  } bin_result_t;

  bin_result_t rotated_bins[$];

  logic [15:0] last_phase[NUM_BINS];
  logic [31:0] last_freq[NUM_BINS];
  logic [15:0] synth_acc[NUM_BINS];
  logic [4:0]  ovl;
  logic [15:0] keep_gain, pitch, ph_gain;
  logic [3:0]  size_lg;

  // atan(2^-k) in 2^-32 turns
  const longint unsigned ATAN32[16] = '{536870912, 316933406, 167458907, 85004756,
    42667331, 21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861};

  function automatic longint turn_step(int k);
    return longint'((ATAN32[k] + (64'd1 << (31 - PB))) >> (32 - PB));
  endfunction

  function automatic longint sx(longint unsigned v, int w);
    longint unsigned m;
    m = (64'd1 << w) - 1;
    v = v & m;
    if (v[w-1]) return longint'(v) - longint'(64'd1 << w);
    return longint'(v);
  endfunction

  function automatic logic [23:0] clip24(longint v);
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return v[23:0];
  endfunction

  task automatic wipe_stores();
    for (int i = 0; i < NUM_BINS; i++) begin
      last_phase[i] = '0;
      last_freq[i] = '0;
      synth_acc[i] = '0;
    end
  endtask

  // propagates one bin's phase and returns the rotated bin; DC, Nyquist and higher bins come back unrotated
  function automatic bin_result_t propagate_bin(logic [11:0] b, logic [23:0] rin,
                                                logic [23:0] iin, logic fe);
    bin_result_t r;
    longint re, im, x, y, z, nx, xs, ys, a, tf;
    longint unsigned half_n, ph, ideal, dev, t1, t2, sum, nph, ov;
    int lg;
    re = sx(rin, 24);
    im = sx(iin, 24);
    lg = size_lg;
    if (lg < 5) lg = 5;
    if (lg > 12) lg = 12;
    half_n = 64'd1 << (lg - 1);
    r.bin = b;
    r.last = fe;
    if (b == 0 || b >= half_n) begin
      r.re = clip24(re);
      r.im = clip24(im);
      return r;
    end
    x = re * 64;
    y = im * 64;
    z = 0;
    if (re != 0 || im != 0) begin
      if (x < 0) begin
        x = -x;
        y = -y;
        z = 32768;
      end
      for (int k = 0; k < 16; k++) begin
        xs = x >>> k;
        ys = y >>> k;
        a = turn_step(k);
        if (y >= 0) begin
          nx = x + ys; y = y - xs; z += a;
        end else begin
          nx = x - ys; y = y + xs; z -= a;
        end
        x = nx;
      end
    end
    ph = longint'(z) & PMASK;
    ov = (ovl == 0) ? 1 : ovl;
    ideal = ((longint'(b) << PB) + ov / 2) / ov;
    dev = (ph - last_phase[b] - ideal) & PMASK;
    tf = longint'(ideal) + sx(dev, PB);
    t1 = longint'(sx(synth_acc[b], PB) * longint'(keep_gain)) << 12;
    t2 = sx(last_freq[b], 32) * longint'(pitch) * longint'(ph_gain);
    sum = t1 + t2;
    nph = ((sum + (64'd1 << 25)) >> 26) & PMASK;
    last_freq[b] = tf[31:0];
    synth_acc[b] = nph[15:0];
    last_phase[b] = ph[15:0];
    z = sx(nph, PB);
    y = 0;
    if (z > 16384) begin
      x = -x; z -= 32768;
    end else if (z < -16384) begin
      x = -x; z += 32768;
    end
    for (int k = 0; k < 16; k++) begin
      xs = x >>> k;
      ys = y >>> k;
      a = turn_step(k);
      if (z >= 0) begin
        nx = x - ys; y = y + xs; z -= a;
      end else begin
        nx = x + ys; y = y - xs; z += a;
      end
      x = nx;
    end
    r.re = clip24((x * longint'(pvbu_pkg::INV_K2_Q30) + (64'sd1 <<< 35)) >>> 36);
    r.im = clip24((y * longint'(pvbu_pkg::INV_K2_Q30) + (64'sd1 <<< 35)) >>> 36);
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("error at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    failures++;
  endtask

  initial begin
    failures = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    bin_result_t e;
    if (rst) begin
      wipe_stores();
      ovl <= 5'd4;
      keep_gain <= 16'd16384;
      pitch <= 16'd4096;
      ph_gain <= 16'd16384;
      size_lg <= 4'd10;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (pvbu_pkg::cfg_index_t'(cfg_index))
          pvbu_pkg::CFG_OVERLAP:    ovl <= cfg_data[4:0];
          pvbu_pkg::CFG_RETENTION:  keep_gain <= cfg_data;
          pvbu_pkg::CFG_SCALE:      pitch <= cfg_data;
          pvbu_pkg::CFG_PHASE_GAIN: ph_gain <= cfg_data;
          pvbu_pkg::CFG_FFT_LOG2:   size_lg <= cfg_data[3:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (kind == KIND_CLEAR) wipe_stores();
        else rotated_bins.push_back(propagate_bin(bin_index, re_in, im_in, frame_end));
      end
      if (out_valid && !out_stall) begin
        if (rotated_bins.size() == 0) begin
          report("unexpected item bin", bin_out, 0);
        end else begin
          e = rotated_bins.pop_front();
          if (bin_out !== e.bin) report("bin_out", bin_out, e.bin);
          if (re_out !== e.re) report("re_out", re_out, e.re);
          if (im_out !== e.im) report("im_out", im_out, e.im);
          if (last_out !== e.last) report("last_out", last_out, e.last);
        end
      end
      pending <= rotated_bins.size();
    end
  end
endmodule

/* tb/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic KIND_BIN = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;
  localparam int STALL_LIMIT = 20000;
  localparam int SETTLE = 2200;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0, kind = 0, frame_end = 0;
  logic [11:0] bin_index = '0;
  logic [23:0] re_in = '0, im_in = '0;
  logic out_stall = 0;
  logic cfg_valid = 0;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  wire in_stall, out_valid, last_out, cfg_ready;
  wire [11:0] bin_out;
  wire [23:0] re_out, im_out;
  int pending, failures;
  int quiet_cycles = 0;
  bit calm = 0;
  int lg_now = 10;

  always #5 clk = ~clk;

  phase_vocoder_bin_update DUT (.*);

  bin_update_checker u_checker (.*);

  // receiver stall bursts
  int stall_left = 0;
  always @(posedge clk) begin
    if (rst || calm) begin
      out_stall <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      out_stall <= !out_stall;
      stall_left <= $urandom_range(0, 7);
    end else begin
      out_stall <= 0;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic write_reg(pvbu_pkg::cfg_index_t idx, logic [15:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    if (idx == pvbu_pkg::CFG_FFT_LOG2) lg_now = val;
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic send(logic k, int b, logic [23:0] r, logic [23:0] i, logic fe);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1;
    kind <= k;
    bin_index <= b[11:0];
    re_in <= r;
    im_in <= i;
    frame_end <= fe;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic logic [23:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'(int'($urandom_range(0, 2000)) - 1000);
      3: return 24'd0;
      default: return $urandom();
    endcase
  endfunction

  task automatic random_items(int n);
    int hn, b;
    hn = 1 << ((lg_now < 5 ? 5 : lg_now) - 1);
    for (int j = 0; j < n; j++) begin
      if ($urandom_range(0, 99) == 0) begin
        send(KIND_CLEAR, $urandom_range(0, 2048), $urandom(), $urandom(), $urandom_range(0, 1));
        continue;
      end
      case ($urandom_range(0, 9))
        0: b = $urandom_range(0, 1) ? 0 : $urandom_range(hn, 2048);
        1, 2, 3: b = $urandom_range(1, hn - 1);
        default: b = $urandom_range(1, hn - 1 < 6 ? hn - 1 : 6);
      endcase
      send(KIND_BIN, b, pick_value(), pick_value(), $urandom_range(0, 1));
    end
    in_valid <= 0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    drain();
    // directed items at reset settings, nyquist at 512
    send(KIND_BIN, 0, 24'h123456, 24'h000000, 0);
    send(KIND_BIN, 512, 24'h800000, 24'h7FFFFF, 0);
    send(KIND_BIN, 1000, 24'h7FFFFF, 24'h800000, 0);
    send(KIND_BIN, 2048, 24'hFFFFFF, 24'h000001, 1);
    send(KIND_BIN, 1, 24'h000000, 24'h000000, 0);
    send(KIND_BIN, 1, 24'h7FFFFF, 24'h7FFFFF, 0);
    send(KIND_BIN, 1, 24'h800000, 24'h800000, 0);
    send(KIND_BIN, 1, 24'h800000, 24'h000000, 0);
    send(KIND_BIN, 511, 24'h800000, 24'h7FFFFF, 1);
    send(KIND_BIN, 511, 24'h7FFFFF, 24'h800000, 0);
    send(KIND_BIN, 2, 24'hFFFFFF, 24'h000000, 0);
    send(KIND_BIN, 3, 24'h000000, 24'hFFFFFF, 0);
    send(KIND_BIN, 3, 24'h000000, 24'h000001, 0);
    send(KIND_BIN, 2047, 24'h555555, 24'hAAAAAA, 1);
    send(KIND_CLEAR, 0, 24'h0, 24'h0, 0);
    send(KIND_BIN, 1, 24'h7FFFFF, 24'h000000, 0);
    in_valid <= 0;
    drain();
    // register extremes, reset values with FFT_LOG2 6, then random settings
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin
          write_reg(pvbu_pkg::CFG_OVERLAP, 1);
          write_reg(pvbu_pkg::CFG_RETENTION, 16'hFFFF);
          write_reg(pvbu_pkg::CFG_SCALE, 16'hFFFF);
          write_reg(pvbu_pkg::CFG_PHASE_GAIN, 16'hFFFF);
          write_reg(pvbu_pkg::CFG_FFT_LOG2, 12);
        end
        1: begin
          write_reg(pvbu_pkg::CFG_OVERLAP, 16);
          write_reg(pvbu_pkg::CFG_RETENTION, 0);
          write_reg(pvbu_pkg::CFG_SCALE, 0);
          write_reg(pvbu_pkg::CFG_PHASE_GAIN, 0);
          write_reg(pvbu_pkg::CFG_FFT_LOG2, 5);
        end
        2: begin
          write_reg(pvbu_pkg::CFG_OVERLAP, 4);
          write_reg(pvbu_pkg::CFG_RETENTION, 16384);
          write_reg(pvbu_pkg::CFG_SCALE, 4096);
          write_reg(pvbu_pkg::CFG_PHASE_GAIN, 16384);
          write_reg(pvbu_pkg::CFG_FFT_LOG2, 6);
        end
        default: begin
          write_reg(pvbu_pkg::CFG_OVERLAP, $urandom_range(1, 16));
          write_reg(pvbu_pkg::CFG_RETENTION, $urandom());
          write_reg(pvbu_pkg::CFG_SCALE, $urandom());
          write_reg(pvbu_pkg::CFG_PHASE_GAIN, $urandom());
          write_reg(pvbu_pkg::CFG_FFT_LOG2, $urandom_range(5, 12));
        end
      endcase
      if (ph == 6) calm = 1;
      random_items(200);
      drain();
    end
    if (failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
